// ===== rtl/ramped_speed_pid_torque_slew_top_defines.svh =====
// assertion macros shared by the speed loop rtl
`ifndef RAMPED_SPEED_PID_TORQUE_SLEW_TOP_DEFINES_SVH
`define RAMPED_SPEED_PID_TORQUE_SLEW_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// checked while out of reset
`define RSPTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked on every edge, reset included
`define RSPTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define RSPTS_ASSERT(lbl, prop, msg)
`define RSPTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/rspts_pkg.sv =====
`default_nettype none
package rspts_pkg;

    // config port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_LIMIT = 3'd4;

    localparam logic [15:0] PROP_GAIN_RST    = 16'd9984;
    localparam logic [15:0] INTEG_GAIN_RST   = 16'd255;
    localparam logic [15:0] DERIV_GAIN_RST   = 16'd127;
    localparam logic [23:0] RAMP_STEP_RST    = 24'd383;
    localparam logic [9:0]  TORQUE_LIMIT_RST = 10'd1000;

    // speed loop runs on the tick after the counter reaches this
    localparam int              LOOP_CNT_W       = 8;
    localparam logic [LOOP_CNT_W-1:0] SPEED_LOOP_LIMIT = 8'd80;

    // q16 speed reference, range about +-2^28
    localparam int REF_W = 30;

    // err = trunc(diff * 2048 / 375); |diff| * ERR_RECIP >> ERR_SHIFT is exact
    // for |diff| < 2^13 since ERR_RECIP = ceil(2^33 / 375)
    localparam int          ERR_RECIP_W = 25;
    localparam logic [ERR_RECIP_W-1:0] ERR_RECIP = 25'd22906493;
    localparam int          ERR_SHIFT   = 22;
    localparam int          ERR_W       = 18;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
        logic [23:0] ramp_step;
        logic [9:0]  torque_limit;
    } cfg_t;

    typedef struct packed {
        logic regulate;
        logic pid_fire;
    } ctl_t;

    typedef struct packed {
        ctl_t               ctl;
        logic signed [12:0] ref_int;
        logic signed [12:0] measured;
    } ramp_t;

    typedef struct packed {
        ctl_t                   ctl;
        logic signed [12:0]     ref_int;
        logic signed [ERR_W-1:0] err;
    } err_t;

    typedef struct packed {
        ctl_t               ctl;
        logic signed [12:0] ref_int;
        logic signed [10:0] torque_cmd;
    } pid_out_t;

endpackage
`default_nettype wire

// ===== rtl/ramped_speed_pid_torque_slew_top.sv =====
// after the input reg, a result passes through these registers in order
//   (ramp, error scale, gain products, integrator, torque clamp, slew/output reg)
// throughput: one item per cycle; a stage holds only while the one after it is full and holding
// reset: synchronous active-low aresetn clears valids, speed reference, integrator,
//   previous error, loop counter, torque command and drive output; config regs return to defaults
`default_nettype none
`include "ramped_speed_pid_torque_slew_top_defines.svh"
module ramped_speed_pid_torque_slew_top (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // config write channel
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [rspts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [rspts_pkg::CFG_DATA_W-1:0]      cfg_data,
    // tick input
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire                                  s_command,
    input  wire signed [12:0]                    s_target_speed,
    input  wire signed [12:0]                    s_measured_speed,
    // result output
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [10:0]                   m_torque_output,
    output logic signed [10:0]                   m_torque_request,
    output logic signed [12:0]                   m_reference_speed
);

    rspts_pkg::cfg_t      cfg_reg;

    // stage handshakes between units
    logic                 ramp_valid;
    logic                 ramp_ready;
    rspts_pkg::ramp_t     ramp_data;
    logic                 err_valid;
    logic                 err_ready;
    rspts_pkg::err_t      err_data;
    logic                 pid_valid;
    logic                 pid_ready;
    rspts_pkg::pid_out_t  pid_data;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain    <= rspts_pkg::PROP_GAIN_RST;
            cfg_reg.integ_gain   <= rspts_pkg::INTEG_GAIN_RST;
            cfg_reg.deriv_gain   <= rspts_pkg::DERIV_GAIN_RST;
            cfg_reg.ramp_step    <= rspts_pkg::RAMP_STEP_RST;
            cfg_reg.torque_limit <= rspts_pkg::TORQUE_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rspts_pkg::REG_PROP_GAIN: begin
                    cfg_reg.prop_gain <= cfg_data[15:0];
                end
                rspts_pkg::REG_INTEG_GAIN: begin
                    cfg_reg.integ_gain <= cfg_data[15:0];
                end
                rspts_pkg::REG_DERIV_GAIN: begin
                    cfg_reg.deriv_gain <= cfg_data[15:0];
                end
                rspts_pkg::REG_RAMP_STEP: begin
                    cfg_reg.ramp_step <= cfg_data[23:0];
                end
                rspts_pkg::REG_TORQUE_LIMIT: begin
                    cfg_reg.torque_limit <= cfg_data[9:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register, reference ramp and loop counter
    rspts_ramp u_ramp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_target_speed   (s_target_speed),
        .s_measured_speed (s_measured_speed),
        .out_valid        (ramp_valid),
        .out_ready        (ramp_ready),
        .out_data         (ramp_data)
    );

    // speed error scaled to the pid's units
    rspts_err u_err (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ramp_valid),
        .in_ready  (ramp_ready),
        .in_data   (ramp_data),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_data  (err_data)
    );

    // pid with clamped integrator and torque command
    rspts_pid u_pid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_data   (err_data),
        .out_valid (pid_valid),
        .out_ready (pid_ready),
        .out_data  (pid_data)
    );

    // drive slew and result register
    rspts_slew u_slew (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (pid_valid),
        .in_ready          (pid_ready),
        .in_data           (pid_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_torque_output   (m_torque_output),
        .m_torque_request  (m_torque_request),
        .m_reference_speed (m_reference_speed)
    );

    // input can only back up when a result sits unclaimed at the output
    `RSPTS_ASSERT(a_stall_source,
        !s_ready |-> (m_valid && !m_ready), "input stalled without output backpressure")

endmodule
`default_nettype wire

// ===== rtl/rspts_ramp.sv =====
`default_nettype none
`include "ramped_speed_pid_torque_slew_top_defines.svh"
module rspts_ramp (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  var rspts_pkg::cfg_t     cfg,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire                     s_command,
    input  wire signed [12:0]       s_target_speed,
    input  wire signed [12:0]       s_measured_speed,
    output logic                    out_valid,
    input  wire                     out_ready,
    output rspts_pkg::ramp_t        out_data
);

    localparam int RW = rspts_pkg::REF_W;

    logic                 v0_reg;
    logic                 cmd_reg;
    logic signed [12:0]   tgt_reg;
    logic signed [12:0]   meas_reg;

    logic                 v1_reg;
    rspts_pkg::ramp_t     s1_reg;
    rspts_pkg::ramp_t     s1_next;

    logic signed [RW-1:0] ref_reg;
    logic signed [RW-1:0] ref_next;
    logic [rspts_pkg::LOOP_CNT_W-1:0] cnt_reg;
    logic [rspts_pkg::LOOP_CNT_W-1:0] cnt_next;
    logic [rspts_pkg::LOOP_CNT_W-1:0] cnt_inc;

    logic signed [RW-1:0] goal;
    logic signed [RW-1:0] meas_q;
    logic signed [RW:0]   goal_x;
    logic signed [RW:0]   ref_up;
    logic signed [RW:0]   ref_dn;
    logic                 fire;
    logic                 en0;
    logic                 en1;

    assign en1     = !v1_reg || out_ready;
    assign en0     = !v0_reg || en1;
    assign s_ready = en0;

    always_comb begin
        goal    = {tgt_reg[12], tgt_reg, 16'h0000};
        meas_q  = {meas_reg[12], meas_reg, 16'h0000};
        goal_x  = {goal[RW-1], goal};
        ref_up  = {ref_reg[RW-1], ref_reg} + {7'd0, cfg.ramp_step};
        ref_dn  = {ref_reg[RW-1], ref_reg} - {7'd0, cfg.ramp_step};
        cnt_inc = cnt_reg + 8'd1;
        fire    = cmd_reg && (cnt_inc > rspts_pkg::SPEED_LOOP_LIMIT);

        if (!cmd_reg) begin
            ref_next = meas_q;
        end else if (goal > ref_reg) begin
            ref_next = (ref_up > goal_x) ? goal : ref_up[RW-1:0];
        end else if (goal < ref_reg) begin
            ref_next = (ref_dn < goal_x) ? goal : ref_dn[RW-1:0];
        end else begin
            ref_next = ref_reg;
        end

        if (!cmd_reg) begin
            cnt_next = cnt_reg;
        end else if (fire) begin
            cnt_next = '0;
        end else begin
            cnt_next = cnt_inc;
        end

        s1_next.ctl.regulate = cmd_reg;
        s1_next.ctl.pid_fire = fire;
        s1_next.ref_int      = ref_next[RW-2:16];
        s1_next.measured     = meas_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            ref_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (en0) begin
                v0_reg <= s_valid;
            end
            if (en1) begin
                v1_reg <= v0_reg;
            end
            if (en1 && v0_reg) begin
                ref_reg <= ref_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en0 && s_valid) begin
            cmd_reg  <= s_command;
            tgt_reg  <= s_target_speed;
            meas_reg <= s_measured_speed;
        end
        if (en1 && v0_reg) begin
            s1_reg <= s1_next;
        end
    end

    assign out_valid = v1_reg;
    assign out_data  = s1_reg;

    `RSPTS_ASSERT(a_fire_clears_count,
        (v1_reg && s1_reg.ctl.pid_fire) |-> (cnt_reg == '0), "loop counter not cleared on pid tick")

endmodule
`default_nettype wire

// ===== rtl/rspts_err.sv =====
`default_nettype none
module rspts_err (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  var rspts_pkg::ramp_t in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output rspts_pkg::err_t     out_data
);

    localparam int EW = rspts_pkg::ERR_W;
    localparam int PW = 13 + rspts_pkg::ERR_RECIP_W;

    logic signed [13:0]   diff;
    logic [13:0]          diff_mag;
    logic [PW-1:0]        prod;
    logic [EW-1:0]        err_mag;
    logic signed [EW-1:0] err;
    logic                 v2_reg;
    rspts_pkg::err_t      s2_reg;
    logic                 en2;

    assign en2      = !v2_reg || out_ready;
    assign in_ready = en2;

    // scale speed error by 65536 / 12000, truncating toward zero
    always_comb begin
        diff     = {in_data.ref_int[12], in_data.ref_int}
                 - {in_data.measured[12], in_data.measured};
        diff_mag = diff[13] ? (14'd0 - diff) : diff;
        prod     = diff_mag[12:0] * rspts_pkg::ERR_RECIP;
        err_mag  = {2'b00, prod[PW-1:rspts_pkg::ERR_SHIFT]};
        err      = diff[13] ? (18'd0 - err_mag) : err_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && in_valid) begin
            s2_reg.ctl     <= in_data.ctl;
            s2_reg.ref_int <= in_data.ref_int;
            s2_reg.err     <= err;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = s2_reg;

endmodule
`default_nettype wire

// ===== rtl/rspts_pid.sv =====
`default_nettype none
`include "ramped_speed_pid_torque_slew_top_defines.svh"
module rspts_pid (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  var rspts_pkg::cfg_t     cfg,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  var rspts_pkg::err_t     in_data,
    output logic                    out_valid,
    input  wire                     out_ready,
    output rspts_pkg::pid_out_t     out_data
);

    localparam int EW = rspts_pkg::ERR_W;

    typedef struct packed {
        rspts_pkg::ctl_t    ctl;
        logic signed [12:0] ref_int;
        logic signed [34:0] prod_p;
        logic signed [34:0] prod_i;
        logic signed [35:0] prod_d;
    } pid3_t;

    typedef struct packed {
        rspts_pkg::ctl_t    ctl;
        logic signed [12:0] ref_int;
        logic signed [36:0] pd_sum;
    } pid4_t;

    logic                 v3_reg;
    logic                 v4_reg;
    logic                 v5_reg;
    pid3_t                s3_reg;
    pid4_t                s4_reg;
    rspts_pkg::pid_out_t  s5_reg;
    logic                 en3;
    logic                 en4;
    logic                 en5;

    logic signed [EW-1:0] prev_err_reg;
    logic signed [26:0]   integ_reg;
    logic signed [26:0]   integ_next;
    logic signed [10:0]   tc_reg;
    logic signed [10:0]   tc_next;

    // stage 3: gain products
    logic signed [16:0]   kp_s;
    logic signed [16:0]   ki_s;
    logic signed [16:0]   kd_s;
    logic signed [EW:0]   delta;
    logic signed [34:0]   prod_p;
    logic signed [34:0]   prod_i;
    logic signed [35:0]   prod_d;

    // stage 4: integrator and p+d
    logic signed [35:0]   integ_sum;
    logic signed [35:0]   lim_q;
    logic signed [35:0]   lim_qn;
    logic signed [36:0]   pd_sum;

    // stage 5: total, scale and clamp
    logic signed [37:0]   total;
    logic signed [21:0]   total_int;
    logic signed [21:0]   lim_t;
    logic signed [21:0]   lim_tn;
    logic signed [10:0]   tc_clamp;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    always_comb begin
        kp_s   = {1'b0, cfg.prop_gain};
        ki_s   = {1'b0, cfg.integ_gain};
        kd_s   = {1'b0, cfg.deriv_gain};
        delta  = {in_data.err[EW-1], in_data.err} - {prev_err_reg[EW-1], prev_err_reg};
        prod_p = in_data.err * kp_s;
        prod_i = in_data.err * ki_s;
        prod_d = delta * kd_s;
    end

    always_comb begin
        integ_sum = {s3_reg.prod_i[34], s3_reg.prod_i} + {{9{integ_reg[26]}}, integ_reg};
        lim_q     = {10'd0, cfg.torque_limit, 16'h0000};
        lim_qn    = 36'd0 - lim_q;
        if (!s3_reg.ctl.pid_fire) begin
            integ_next = integ_reg;
        end else if (integ_sum > lim_q) begin
            integ_next = lim_q[26:0];
        end else if (integ_sum < lim_qn) begin
            integ_next = lim_qn[26:0];
        end else begin
            integ_next = integ_sum[26:0];
        end
        pd_sum = {{2{s3_reg.prod_p[34]}}, s3_reg.prod_p} + {s3_reg.prod_d[35], s3_reg.prod_d};
    end

    always_comb begin
        total     = {s4_reg.pd_sum[36], s4_reg.pd_sum} + {{11{integ_reg[26]}}, integ_reg};
        total_int = total[37:16];
        lim_t     = {12'd0, cfg.torque_limit};
        lim_tn    = 22'd0 - lim_t;
        if (total_int > lim_t) begin
            tc_clamp = lim_t[10:0];
        end else if (total_int < lim_tn) begin
            tc_clamp = lim_tn[10:0];
        end else begin
            tc_clamp = total_int[10:0];
        end
        tc_next = s4_reg.ctl.pid_fire ? tc_clamp : tc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            tc_reg       <= '0;
        end else begin
            if (en3) begin
                v3_reg <= in_valid;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
            if (en3 && in_valid && in_data.ctl.pid_fire) begin
                prev_err_reg <= in_data.err;
            end
            if (en4 && v3_reg) begin
                integ_reg <= integ_next;
            end
            if (en5 && v4_reg) begin
                tc_reg <= tc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && in_valid) begin
            s3_reg.ctl     <= in_data.ctl;
            s3_reg.ref_int <= in_data.ref_int;
            s3_reg.prod_p  <= prod_p;
            s3_reg.prod_i  <= prod_i;
            s3_reg.prod_d  <= prod_d;
        end
        if (en4 && v3_reg) begin
            s4_reg.ctl     <= s3_reg.ctl;
            s4_reg.ref_int <= s3_reg.ref_int;
            s4_reg.pd_sum  <= pd_sum;
        end
        if (en5 && v4_reg) begin
            s5_reg.ctl        <= s4_reg.ctl;
            s5_reg.ref_int    <= s4_reg.ref_int;
            s5_reg.torque_cmd <= tc_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = s5_reg;

    // pid ticks are many items apart, so the integrator is never read stale
    `RSPTS_ASSERT(a_pid_spacing_45,
        !(v4_reg && s4_reg.ctl.pid_fire && v5_reg && s5_reg.ctl.pid_fire), "pid ticks too close")
    `RSPTS_ASSERT(a_pid_spacing_34,
        !(v3_reg && s3_reg.ctl.pid_fire && v4_reg && s4_reg.ctl.pid_fire), "pid ticks too close")

endmodule
`default_nettype wire

// ===== rtl/rspts_slew.sv =====
`default_nettype none
`include "ramped_speed_pid_torque_slew_top_defines.svh"
module rspts_slew (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  var rspts_pkg::pid_out_t     in_data,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic signed [10:0]          m_torque_output,
    output logic signed [10:0]          m_torque_request,
    output logic signed [12:0]          m_reference_speed
);

    logic               valid_reg;
    logic signed [10:0] drive_reg;
    logic signed [10:0] drive_next;
    logic signed [10:0] req_reg;
    logic signed [12:0] ref_reg;
    logic signed [11:0] t_x;
    logic signed [11:0] d_x;
    logic [11:0]        t_mag;
    logic [11:0]        d_mag;
    logic signed [11:0] d_up;
    logic signed [11:0] d_dn;
    logic               en;

    assign en       = !valid_reg || m_ready;
    assign in_ready = en;

    // move by 2 toward the command, or jump when it is not larger; hold while not regulating
    always_comb begin
        t_x   = {in_data.torque_cmd[10], in_data.torque_cmd};
        d_x   = {drive_reg[10], drive_reg};
        t_mag = t_x[11] ? (12'd0 - t_x) : t_x;
        d_mag = d_x[11] ? (12'd0 - d_x) : d_x;
        d_up  = d_x + 12'sd2;
        d_dn  = d_x - 12'sd2;
        if (!in_data.ctl.regulate) begin
            drive_next = drive_reg;
        end else if (t_mag <= d_mag) begin
            drive_next = in_data.torque_cmd;
        end else if (d_x > t_x) begin
            drive_next = (d_dn <= t_x) ? in_data.torque_cmd : d_dn[10:0];
        end else if (d_x < t_x) begin
            drive_next = (d_up >= t_x) ? in_data.torque_cmd : d_up[10:0];
        end else begin
            drive_next = in_data.torque_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            drive_reg <= '0;
        end else begin
            if (en) begin
                valid_reg <= in_valid;
            end
            if (en && in_valid) begin
                drive_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            req_reg <= in_data.torque_cmd;
            ref_reg <= in_data.ref_int;
        end
    end

    assign m_valid           = valid_reg;
    assign m_torque_output   = drive_reg;
    assign m_torque_request  = req_reg;
    assign m_reference_speed = ref_reg;

    `RSPTS_ASSERT(a_slew_step,
        (en && in_valid) |=> (drive_reg == req_reg) || (drive_reg == $past(drive_reg))
        || (drive_reg == $past(drive_reg) + 11'sd2) || (drive_reg == $past(drive_reg) - 11'sd2),
        "drive moved by more than the slew step")

endmodule
`default_nettype wire
